/* rtl/awu_pkg.sv */
package awu_pkg;

    localparam int GRAD_W    = 32;
    localparam int ACC_W     = 48;
    localparam int PARAM_W   = 32;
    localparam int LR_W      = 32;
    localparam int EPS_W     = 24;
    localparam int FRAC_W    = 24;
    localparam int SQ_W      = 2 * GRAD_W - FRAC_W;
    localparam int NUM_W     = LR_W + GRAD_W;
    localparam int ROOT_W    = (ACC_W + FRAC_W) / 2;
    localparam int DIV_W     = ROOT_W + 1;
    localparam int QUO_W     = 34;
    localparam int RES_W     = QUO_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam int SQ_RPS = 2;
    localparam int DV_RPS = 2;

    localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
    localparam logic [QUO_W-1:0]  STEP_CAP = QUO_W'(64'h2_0000_0000);
    localparam logic [LR_W-1:0]   LR_RESET = LR_W'(167772);
    localparam logic [EPS_W-1:0]  EPS_RESET = EPS_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_LR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EPS = 1'b1;

    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic               neg;
        logic [PARAM_W-1:0] param;
        logic               last;
        logic               sat;
        logic [ACC_W-1:0]   acc;
    } sq_side_t;

    typedef struct packed {
        logic               neg;
        logic [PARAM_W-1:0] param;
        logic               last;
        logic               sat;
        logic [ACC_W-1:0]   acc;
    } dv_side_t;

endpackage

/* rtl/awu_in_if.sv */
interface awu_in_if import awu_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [GRAD_W-1:0]  gradient;
    logic [ACC_W-1:0]          accum_in;
    logic signed [PARAM_W-1:0] param_in;
    logic                      last_in;

    modport source (output valid, gradient, accum_in, param_in, last_in, input ready);
    modport sink (input valid, gradient, accum_in, param_in, last_in, output ready);
endinterface

/* rtl/awu_out_if.sv */
interface awu_out_if import awu_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [ACC_W-1:0]          accum_out;
    logic signed [PARAM_W-1:0] param_out;
    logic                      last_out;
    logic                      saturated;

    modport source (output valid, accum_out, param_out, last_out, saturated, input ready);
    modport sink (input valid, accum_out, param_out, last_out, saturated, output ready);
endinterface

/* rtl/adagrad_weight_update_core.sv */
// Adagrad weight update, one weight per transfer. The core accepts a new weight
// in every cycle in which no result is held at the output; the pipeline depth is
// set by the pipelined square root, SQ_RPS result bits per stage, and the
// pipelined divider, DV_RPS quotient bits per stage. The whole pipeline holds
// while a result waits at the output. learning_rate and epsilon are written
// through the plain write port and must only change while no weight is in flight.
module adagrad_weight_update_core
    import awu_pkg::*;
#(
    parameter int SQ_RPS_P = SQ_RPS,
    parameter int DV_RPS_P = DV_RPS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    awu_in_if.sink                upd_in,
    awu_out_if.source             upd_out
);
    logic [LR_W-1:0]  lr_reg;
    logic [EPS_W-1:0] eps_reg;
    logic             en;

    logic               valid0_reg;
    logic [GRAD_W-1:0]  gmag0_reg;
    logic               neg0_reg;
    logic [PARAM_W-1:0] param0_reg;
    logic [ACC_W-1:0]   acc0_reg;
    logic               last0_reg;
    logic [GRAD_W-1:0]  g_raw;
    logic [GRAD_W-1:0]  gmag_next;

    logic               valid1_reg;
    logic [SQ_W-1:0]    sq1_reg;
    logic [NUM_W-1:0]   num1_reg;
    logic               neg1_reg;
    logic [PARAM_W-1:0] param1_reg;
    logic [ACC_W-1:0]   acc1_reg;
    logic               last1_reg;
    logic [2*GRAD_W-1:0] sq_prod;
    logic [NUM_W-1:0]   num_prod;

    logic               valid2_reg;
    sq_side_t           side2_reg;
    logic [ACC_W:0]     acc_sum;
    sq_side_t           side2_next;

    logic               sq_valid;
    logic [ROOT_W-1:0]  root;
    sq_side_t           sq_side;

    logic               valid3_reg;
    logic [DIV_W-1:0]   div3_reg;
    logic [NUM_W-1:0]   num3_reg;
    dv_side_t           side3_reg;

    logic               dv_valid;
    logic [QUO_W-1:0]   quo;
    logic               dv_ovf;
    logic               dv_zero;
    dv_side_t           dv_side;

    logic [QUO_W-1:0]   step;
    logic signed [RES_W-1:0] res;
    logic               res_hi;
    logic               res_lo;

    logic               out_valid_reg;
    logic [ACC_W-1:0]   accum_out_reg;
    logic [PARAM_W-1:0] param_out_reg;
    logic               last_out_reg;
    logic               saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg  <= LR_RESET;
            eps_reg <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LR:  lr_reg  <= cfg_data[LR_W-1:0];
                REG_EPS: eps_reg <= cfg_data[EPS_W-1:0];
            endcase
        end
    end

    assign en           = !out_valid_reg || upd_out.ready;
    assign upd_in.ready = en;

    // magnitude of the gradient
    assign g_raw     = upd_in.gradient;
    assign gmag_next = g_raw[GRAD_W-1] ? (~g_raw + 1'b1) : g_raw;

    // square and learning-rate products
    assign sq_prod  = (2*GRAD_W)'(gmag0_reg) * (2*GRAD_W)'(gmag0_reg);
    assign num_prod = NUM_W'(lr_reg) * NUM_W'(gmag0_reg);

    // saturating accumulator update
    assign acc_sum = {1'b0, acc1_reg} + (ACC_W+1)'(sq1_reg);

    always_comb
    begin
        side2_next.num   = num1_reg;
        side2_next.neg   = neg1_reg;
        side2_next.param = param1_reg;
        side2_next.last  = last1_reg;
        side2_next.sat   = acc_sum[ACC_W];
        side2_next.acc   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg    <= 1'b0;
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            valid3_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid0_reg    <= upd_in.valid;
            valid1_reg    <= valid0_reg;
            valid2_reg    <= valid1_reg;
            valid3_reg    <= sq_valid;
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gmag0_reg  <= gmag_next;
            neg0_reg   <= g_raw[GRAD_W-1];
            param0_reg <= upd_in.param_in;
            acc0_reg   <= upd_in.accum_in;
            last0_reg  <= upd_in.last_in;

            sq1_reg    <= sq_prod[2*GRAD_W-1:FRAC_W];
            num1_reg   <= num_prod;
            neg1_reg   <= neg0_reg;
            param1_reg <= param0_reg;
            acc1_reg   <= acc0_reg;
            last1_reg  <= last0_reg;

            side2_reg  <= side2_next;

            div3_reg        <= {1'b0, root} + DIV_W'(eps_reg);
            num3_reg        <= sq_side.num;
            side3_reg.neg   <= sq_side.neg;
            side3_reg.param <= sq_side.param;
            side3_reg.last  <= sq_side.last;
            side3_reg.sat   <= sq_side.sat;
            side3_reg.acc   <= sq_side.acc;

            accum_out_reg <= dv_side.acc;
            param_out_reg <= res_hi ? {1'b0, {(PARAM_W-1){1'b1}}} :
                             res_lo ? {1'b1, {(PARAM_W-1){1'b0}}} : res[PARAM_W-1:0];
            last_out_reg  <= dv_side.last;
            saturated_reg <= dv_side.sat || res_hi || res_lo;
        end
    end

    awu_isqrt #(.RPS(SQ_RPS_P)) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid2_reg),
        .value     (side2_reg.acc),
        .in_side   (side2_reg),
        .out_valid (sq_valid),
        .root      (root),
        .out_side  (sq_side)
    );

    awu_div #(.RPS(DV_RPS_P)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid3_reg),
        .num       (num3_reg),
        .divisor   (div3_reg),
        .in_side   (side3_reg),
        .out_valid (dv_valid),
        .quo       (quo),
        .ovf       (dv_ovf),
        .zero      (dv_zero),
        .out_side  (dv_side)
    );

    // step with cap, then signed weight update and clamp
    always_comb
    begin
        if (dv_zero)
        begin
            step = '0;
        end
        else if (dv_ovf || quo > STEP_CAP)
        begin
            step = STEP_CAP;
        end
        else
        begin
            step = quo;
        end
    end

    assign res = dv_side.neg ?
                 RES_W'(signed'(dv_side.param)) + signed'({1'b0, step}) :
                 RES_W'(signed'(dv_side.param)) - signed'({1'b0, step});
    assign res_hi = res > RES_W'(signed'({1'b0, {(PARAM_W-1){1'b1}}}));
    assign res_lo = res < RES_W'(signed'({1'b1, {(PARAM_W-1){1'b0}}}));

    assign upd_out.valid     = out_valid_reg;
    assign upd_out.accum_out = accum_out_reg;
    assign upd_out.param_out = param_out_reg;
    assign upd_out.last_out  = last_out_reg;
    assign upd_out.saturated = saturated_reg;

    // clamping shows at the accumulator ceiling or a weight limit
    sat_source_a: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_out.valid && upd_out.saturated) |->
        (upd_out.accum_out == ACC_MAX ||
         upd_out.param_out == {1'b0, {(PARAM_W-1){1'b1}}} ||
         upd_out.param_out == {1'b1, {(PARAM_W-1){1'b0}}}))
        else $error("saturated without a clamped value");

    // a zero divisor only follows an empty accumulator
    zero_div_a: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid && dv_zero) |-> (dv_side.acc == '0))
        else $error("zero divisor with non-zero accumulator");

    root_low_a: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid |-> ((2*ROOT_W)'(root) * (2*ROOT_W)'(root) <= {sq_side.acc, {FRAC_W{1'b0}}}))
        else $error("square root too large");

    root_high_a: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid |-> (((2*ROOT_W+2)'(root) + 1'b1) * ((2*ROOT_W+2)'(root) + 1'b1) >
                      (2*ROOT_W+2)'({sq_side.acc, {FRAC_W{1'b0}}})))
        else $error("square root too small");

endmodule

/* rtl/awu_isqrt.sv */
module awu_isqrt
    import awu_pkg::*;
#(
    parameter int RPS = SQ_RPS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ACC_W-1:0]  value,
    input  sq_side_t          in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output sq_side_t          out_side
);
    localparam int STAGES = (ROOT_W + RPS - 1) / RPS;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 4;

    logic              valid_reg [STAGES];
    logic [RAD_W-1:0]  rad_reg   [STAGES];
    logic [REM_W-1:0]  rem_reg   [STAGES];
    logic [ROOT_W-1:0] root_reg  [STAGES];
    sq_side_t          side_reg  [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic              valid_prev;
        logic [RAD_W-1:0]  rad_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        sq_side_t          side_prev;
        logic [RAD_W-1:0]  rad_next;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (s == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rad_prev   = {value, {(RAD_W - ACC_W){1'b0}}};
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign side_prev  = in_side;
        end
        else begin : g_rest
            assign valid_prev = valid_reg[s-1];
            assign rad_prev   = rad_reg[s-1];
            assign rem_prev   = rem_reg[s-1];
            assign root_prev  = root_reg[s-1];
            assign side_prev  = side_reg[s-1];
        end

        always_comb
        begin
            logic [RAD_W-1:0]  rad;
            logic [REM_W-1:0]  rem;
            logic [REM_W-1:0]  trial;
            logic [ROOT_W-1:0] rt;
            rad = rad_prev;
            rem = rem_prev;
            rt  = root_prev;
            for (int r = 0; r < RPS; r++)
            begin
                if (s * RPS + r < ROOT_W)
                begin
                    rem   = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
                    rad   = {rad[RAD_W-3:0], 2'b00};
                    trial = {{(REM_W - ROOT_W - 2){1'b0}}, rt, 2'b01};
                    if (rem >= trial)
                    begin
                        rem = rem - trial;
                        rt  = {rt[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rt = {rt[ROOT_W-2:0], 1'b0};
                    end
                end
            end
            rad_next  = rad;
            rem_next  = rem;
            root_next = rt;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s]  <= rad_next;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign root      = root_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

/* rtl/awu_div.sv */
module awu_div
    import awu_pkg::*;
#(
    parameter int RPS = DV_RPS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DIV_W-1:0] divisor,
    input  dv_side_t         in_side,
    output logic             out_valid,
    output logic [QUO_W-1:0] quo,
    output logic             ovf,
    output logic             zero,
    output dv_side_t         out_side
);
    localparam int STAGES = (QUO_W + RPS - 1) / RPS;
    localparam int HI_W   = NUM_W - QUO_W;

    logic             valid_reg [STAGES];
    logic [QUO_W-1:0] low_reg   [STAGES];
    logic [DIV_W-1:0] rem_reg   [STAGES];
    logic [QUO_W-1:0] quo_reg   [STAGES];
    logic [DIV_W-1:0] div_reg   [STAGES];
    logic             ovf_reg   [STAGES];
    logic             zero_reg  [STAGES];
    dv_side_t         side_reg  [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic             valid_prev;
        logic [QUO_W-1:0] low_prev;
        logic [DIV_W-1:0] rem_prev;
        logic [QUO_W-1:0] quo_prev;
        logic [DIV_W-1:0] div_prev;
        logic             ovf_prev;
        logic             zero_prev;
        dv_side_t         side_prev;
        logic [QUO_W-1:0] low_next;
        logic [DIV_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (s == 0) begin : g_first
            assign valid_prev = in_valid;
            assign low_prev   = num[QUO_W-1:0];
            assign rem_prev   = DIV_W'(num[NUM_W-1 -: HI_W]);
            assign quo_prev   = '0;
            assign div_prev   = divisor;
            assign ovf_prev   = DIV_W'(num[NUM_W-1 -: HI_W]) >= divisor;
            assign zero_prev  = (divisor == '0);
            assign side_prev  = in_side;
        end
        else begin : g_rest
            assign valid_prev = valid_reg[s-1];
            assign low_prev   = low_reg[s-1];
            assign rem_prev   = rem_reg[s-1];
            assign quo_prev   = quo_reg[s-1];
            assign div_prev   = div_reg[s-1];
            assign ovf_prev   = ovf_reg[s-1];
            assign zero_prev  = zero_reg[s-1];
            assign side_prev  = side_reg[s-1];
        end

        always_comb
        begin
            logic [QUO_W-1:0] low;
            logic [DIV_W:0]   rem;
            logic [QUO_W-1:0] q;
            low = low_prev;
            rem = {1'b0, rem_prev};
            q   = quo_prev;
            for (int r = 0; r < RPS; r++)
            begin
                if (s * RPS + r < QUO_W)
                begin
                    rem = {rem[DIV_W-1:0], low[QUO_W-1]};
                    low = {low[QUO_W-2:0], 1'b0};
                    if (rem >= {1'b0, div_prev})
                    begin
                        rem = rem - {1'b0, div_prev};
                        q   = {q[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[QUO_W-2:0], 1'b0};
                    end
                end
            end
            low_next = low;
            rem_next = rem[DIV_W-1:0];
            quo_next = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                low_reg[s]  <= low_next;
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
                div_reg[s]  <= div_prev;
                ovf_reg[s]  <= ovf_prev;
                zero_reg[s] <= zero_prev;
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quo       = quo_reg[STAGES-1];
    assign ovf       = ovf_reg[STAGES-1];
    assign zero      = zero_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule
